>>> hw/rtl/bcrc_pkg.sv
// ----------------------------------------------------------------------------
// bcrc_pkg
// Shared types, constants and the byte-wide CRC-32 update for the event
// trailer checker.
// ----------------------------------------------------------------------------
`default_nettype none

package bcrc_pkg;

  // trailer length in bytes and CRC constants
  localparam int unsigned TRAILER_BYTES = 4;
  localparam logic [31:0] CRC_POLY      = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT      = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_XOROUT    = 32'hFFFF_FFFF;

  // configuration port geometry
  localparam int unsigned CFG_ADDR_W = 5;
  localparam int unsigned REG_IDX_W  = 3;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_CHECK_ENABLE     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_TYPE_OFFSET      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_FLAGS_POS        = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_FORMAT_DESC_TYPE = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_IN_USE_MASK      = 3'd4;

  // reset values of the registers
  localparam logic       RST_CHECK_ENABLE     = 1'b1;
  localparam logic [7:0] RST_TYPE_OFFSET      = 8'd4;
  localparam logic [7:0] RST_FLAGS_POS        = 8'd17;
  localparam logic [7:0] RST_FORMAT_DESC_TYPE = 8'd15;
  localparam logic [7:0] RST_IN_USE_MASK      = 8'd1;

  // input transaction payload
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  // result transaction payload
  typedef struct packed {
    logic        mismatch;
    logic        too_short;
    logic [31:0] computed_crc;
    logic [31:0] received_crc;
  } out_item_t;

  // configuration seen by the checking core
  typedef struct packed {
    logic       check_enable;
    logic [7:0] type_offset;
    logic [7:0] flags_pos;
    logic [7:0] format_desc_type;
    logic [7:0] in_use_mask;
  } cfg_t;

  // reflected CRC-32 over one byte, unrolled into an xor network
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/bcrc_core.sv
// ----------------------------------------------------------------------------
// bcrc_core
// Per-event state of the trailer checker: position counter, format
// description detection, four-byte trailer delay line and CRC accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module bcrc_core #(
  parameter int unsigned POSITION_WIDTH = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire bcrc_pkg::in_item_t item,
  input  wire bcrc_pkg::cfg_t    cfg,
  output logic                   res_valid,
  output bcrc_pkg::out_item_t    res
);
  import bcrc_pkg::*;

  localparam logic [POSITION_WIDTH-1:0] POS_MAX = {POSITION_WIDTH{1'b1}};

  logic [POSITION_WIDTH-1:0] pos_r, pos_nxt;
  logic                      fd_r, fd_nxt;
  logic [31:0]               crc_r, crc_nxt;
  logic [7:0]                dly_r [TRAILER_BYTES];
  logic [7:0]                dly_nxt [TRAILER_BYTES];

  logic                      fd_now;
  logic [7:0]                b_mod;
  logic [31:0]               crc_upd;
  logic [31:0]               received;
  logic [31:0]               computed;
  logic                      short_ev;

  // type detection and flag clearing on the incoming byte
  always_comb begin
    fd_now = fd_r;
    if (pos_r == POSITION_WIDTH'(cfg.type_offset)) begin
      fd_now = (item.data_byte == cfg.format_desc_type);
    end
    b_mod = item.data_byte;
    if ((pos_r == POSITION_WIDTH'(cfg.flags_pos)) && fd_now) begin
      b_mod = item.data_byte & ~cfg.in_use_mask;
    end
  end

  // oldest delayed byte enters the crc once the line is full
  assign crc_upd = (pos_r >= POSITION_WIDTH'(TRAILER_BYTES))
                 ? crc32_byte(crc_r, dly_r[TRAILER_BYTES-1]) : crc_r;

  // trailer as little-endian word: newest byte is the top byte
  assign received = {b_mod, dly_r[0], dly_r[1], dly_r[2]};
  assign computed = crc_upd ^ CRC_XOROUT;
  assign short_ev = pos_r < POSITION_WIDTH'(TRAILER_BYTES - 1);

  always_comb begin
    res_valid        = step && item.last_byte;
    res.too_short    = short_ev;
    res.computed_crc = computed;
    res.received_crc = received;
    res.mismatch     = cfg.check_enable && (short_ev || (computed != received));
  end

  // next state, cleared after the last byte of an event
  always_comb begin
    pos_nxt = pos_r;
    fd_nxt  = fd_r;
    crc_nxt = crc_r;
    for (int i = 0; i < TRAILER_BYTES; i++) begin
      dly_nxt[i] = dly_r[i];
    end
    if (step) begin
      if (item.last_byte) begin
        pos_nxt = '0;
        fd_nxt  = 1'b0;
        crc_nxt = CRC_INIT;
        for (int i = 0; i < TRAILER_BYTES; i++) begin
          dly_nxt[i] = 8'd0;
        end
      end else begin
        pos_nxt = (pos_r != POS_MAX) ? pos_r + 1'b1 : pos_r;
        fd_nxt  = fd_now;
        crc_nxt = crc_upd;
        dly_nxt[0] = b_mod;
        for (int i = 1; i < TRAILER_BYTES; i++) begin
          dly_nxt[i] = dly_r[i-1];
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      fd_r  <= 1'b0;
      crc_r <= CRC_INIT;
      for (int i = 0; i < TRAILER_BYTES; i++) begin
        dly_r[i] <= 8'd0;
      end
    end else begin
      pos_r <= pos_nxt;
      fd_r  <= fd_nxt;
      crc_r <= crc_nxt;
      for (int i = 0; i < TRAILER_BYTES; i++) begin
        dly_r[i] <= dly_nxt[i];
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/binlog_event_crc32_verify.sv
// ----------------------------------------------------------------------------
// binlog_event_crc32_verify
// Checks the little-endian CRC-32 trailer of serialized log events.
// ----------------------------------------------------------------------------
// The block takes one event byte per transaction and sustains one byte per
// clock cycle while the output register is free or being read; the limit is
// the byte-wide CRC-32 update on the accumulator register. A byte is held in
// an input register until it is processed; when it carries the last-byte
// marker, its result then goes to the output register. While a result waits
// there, the byte behind it is held back. Results are produced only on last
// bytes; events shorter than four bytes are flagged as too short. Registers
// must be written over the APB port only while no event is in flight; the block does not enforce this.
`default_nettype none

module binlog_event_crc32_verify #(
  parameter int unsigned POSITION_WIDTH = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // input channel
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire bcrc_pkg::in_item_t                in_data,
  // result channel
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output bcrc_pkg::out_item_t                    out_data,
  // configuration port
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [bcrc_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire logic [31:0]                       pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready
);
  import bcrc_pkg::*;

  cfg_t                 cfg_r;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  logic                 s1_valid_r;
  in_item_t             s1_item_r;
  logic                 out_valid_r;
  out_item_t            out_item_r;
  logic                 step;
  logic                 res_valid;
  out_item_t            res;

  // register access
  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.check_enable     <= RST_CHECK_ENABLE;
      cfg_r.type_offset      <= RST_TYPE_OFFSET;
      cfg_r.flags_pos        <= RST_FLAGS_POS;
      cfg_r.format_desc_type <= RST_FORMAT_DESC_TYPE;
      cfg_r.in_use_mask      <= RST_IN_USE_MASK;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_CHECK_ENABLE:     cfg_r.check_enable     <= pwdata[0];
        REG_TYPE_OFFSET:      cfg_r.type_offset      <= pwdata[7:0];
        REG_FLAGS_POS:        cfg_r.flags_pos        <= pwdata[7:0];
        REG_FORMAT_DESC_TYPE: cfg_r.format_desc_type <= pwdata[7:0];
        REG_IN_USE_MASK:      cfg_r.in_use_mask      <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // register read-back
  always_comb begin
    unique case (reg_idx)
      REG_CHECK_ENABLE:     prdata = {31'd0, cfg_r.check_enable};
      REG_TYPE_OFFSET:      prdata = {24'd0, cfg_r.type_offset};
      REG_FLAGS_POS:        prdata = {24'd0, cfg_r.flags_pos};
      REG_FORMAT_DESC_TYPE: prdata = {24'd0, cfg_r.format_desc_type};
      REG_IN_USE_MASK:      prdata = {24'd0, cfg_r.in_use_mask};
      default:              prdata = 32'd0;
    endcase
  end

  // input register advances whenever the output register can take a result
  assign step     = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_data;
    end
  end

  // checking core
  bcrc_core #(
    .POSITION_WIDTH(POSITION_WIDTH)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .item     (s1_item_r),
    .cfg      (cfg_r),
    .res_valid(res_valid),
    .res      (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule

`default_nettype wire
